@@ hdl/tilt_gated_double_press_classifier_unit_defines.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the tilt-gated double-press classifier
// ---------------------------------------------------------------------------
`ifndef TILT_GATED_DOUBLE_PRESS_CLASSIFIER_UNIT_DEFINES_SVH
`define TILT_GATED_DOUBLE_PRESS_CLASSIFIER_UNIT_DEFINES_SVH

// Same-cycle implication, ignored while reset is asserted.
`define TGDP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("tgdp: same-cycle check failed");

// Next-cycle implication, ignored while reset is asserted.
`define TGDP_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("tgdp: next-cycle check failed");

// Next-cycle implication that also covers reset cycles.
`define TGDP_ASSERT_RST(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("tgdp: reset check failed");

`endif

@@ hdl/tgdp_pkg.sv @@
// ---------------------------------------------------------------------------
// tgdp_pkg
// Shared widths, codes and item types of the tilt-gated double-press classifier.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tgdp_pkg;

    localparam int TIME_W  = 32;
    localparam int ID_W    = 8;
    localparam int ACCEL_W = 16;
    localparam int WIN_W   = 16;
    localparam int HOLD_W  = 8;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_ENABLE    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW    = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_HOLDOFF   = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_TILT_LOW  = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_TILT_HIGH = CFG_IDX_W'(4);

    // Reset values of the registers
    localparam logic [WIN_W-1:0]          RST_WINDOW    = WIN_W'(300);
    localparam logic [HOLD_W-1:0]         RST_HOLDOFF   = HOLD_W'(10);
    localparam logic signed [ACCEL_W-1:0] RST_TILT_LOW  = ACCEL_W'(1280);
    localparam logic signed [ACCEL_W-1:0] RST_TILT_HIGH = ACCEL_W'(3840);

    // Button codes
    localparam logic [1:0] BTN_LEFT  = 2'd0;
    localparam logic [1:0] BTN_RIGHT = 2'd1;
    localparam logic [1:0] BTN_BOTH  = 2'd2;

    typedef struct packed {
        logic                      release_both;
        logic                      release_right;
        logic                      release_left;
        logic signed [ACCEL_W-1:0] accel_z;
        logic [ID_W-1:0]           beacon_id;
        logic                      beacon_present;
        logic [TIME_W-1:0]         time_ms;
    } in_item_t;

    typedef struct packed {
        logic [ID_W-1:0] target_id;
        logic            target_valid;
        logic            is_double;
        logic [1:0]      button_code;
    } out_data_t;

    typedef struct packed {
        logic      last;
        out_data_t data;
    } res_t;

    typedef struct packed {
        logic                      enable;
        logic [WIN_W-1:0]          window_ms;
        logic [HOLD_W-1:0]         holdoff_passes;
        logic signed [ACCEL_W-1:0] tilt_low;
        logic signed [ACCEL_W-1:0] tilt_high;
    } cfg_t;

    localparam int IN_BITS   = $bits(in_item_t);
    localparam int OUT_BITS  = $bits(out_data_t);
    localparam int S_TDATA_W = ((IN_BITS + 7) / 8) * 8;
    localparam int M_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    // Result queue
    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = 3;

endpackage

`default_nettype wire

@@ hdl/tgdp_core.sv @@
// ---------------------------------------------------------------------------
// tgdp_core
// Classification state and per-pass decision logic; up to two results a pass.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tgdp_core (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              fire,
    input  wire tgdp_pkg::in_item_t item,
    input  wire tgdp_pkg::cfg_t    cfg,
    output tgdp_pkg::res_t         res0,
    output tgdp_pkg::res_t         res1,
    output logic [1:0]             res_cnt
);

    logic                          pending_reg, pending_next;
    logic                          pbtn_reg, pbtn_next;
    logic [tgdp_pkg::TIME_W-1:0]   ptime_reg, ptime_next;
    logic [tgdp_pkg::HOLD_W-1:0]   hold_reg, hold_next;

    logic                          qual;
    logic [tgdp_pkg::TIME_W-1:0]   gap, gap_end;
    logic [tgdp_pkg::TIME_W-1:0]   window;
    logic                          in_window;
    logic                          new_btn;
    logic                          a_v, b_v, t_v;
    tgdp_pkg::out_data_t           a_d, b_d, t_d;
    logic [tgdp_pkg::ID_W-1:0]     tid;

    assign window = tgdp_pkg::TIME_W'(cfg.window_ms);
    assign qual   = item.beacon_present
                  && ($signed(item.accel_z) > $signed(cfg.tilt_low))
                  && ($signed(item.accel_z) < $signed(cfg.tilt_high));
    assign gap    = item.time_ms - ptime_reg;
    assign in_window = pending_reg && (gap <= window);
    assign new_btn = item.release_left ? 1'b0 : 1'b1;
    assign tid    = item.beacon_present ? item.beacon_id : '0;

    always_comb begin
        pending_next = pending_reg;
        pbtn_next    = pbtn_reg;
        ptime_next   = ptime_reg;
        hold_next    = hold_reg;
        a_v = 1'b0;
        b_v = 1'b0;
        a_d = '{target_id: tid, target_valid: item.beacon_present, is_double: 1'b0,
                button_code: {1'b0, pbtn_reg}};
        b_d = '{target_id: tid, target_valid: item.beacon_present, is_double: 1'b0,
                button_code: tgdp_pkg::BTN_BOTH};
        if (cfg.enable && qual) begin
            if (hold_reg != '0) begin
                hold_next = hold_reg - 1'b1;
            end else if (item.release_both) begin
                // flush the pending press first, then report the both-release
                a_v          = pending_reg;
                b_v          = 1'b1;
                pending_next = 1'b0;
                hold_next    = cfg.holdoff_passes;
            end else if (item.release_left || item.release_right) begin
                if (in_window && (pbtn_reg == new_btn)) begin
                    b_v               = 1'b1;
                    b_d.is_double     = 1'b1;
                    b_d.button_code   = {1'b0, new_btn};
                    pending_next      = 1'b0;
                end else begin
                    a_v          = pending_reg;
                    pending_next = 1'b1;
                    pbtn_next    = new_btn;
                    ptime_next   = item.time_ms;
                end
            end
        end
    end

    // Timeout on the state left by this pass
    assign gap_end = item.time_ms - ptime_next;
    assign t_v = cfg.enable && pending_next && (gap_end > window);
    assign t_d = '{target_id: tid, target_valid: item.beacon_present, is_double: 1'b0,
                   button_code: {1'b0, pbtn_next}};

    // Only {a}, {a,b}, {b} or {t} can occur
    always_comb begin
        res_cnt   = 2'(a_v) + 2'(b_v) + 2'(t_v);
        res0.data = a_v ? a_d : (b_v ? b_d : t_d);
        res0.last = (res_cnt == 2'd1);
        res1.data = b_d;
        res1.last = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= 1'b0;
            pbtn_reg    <= 1'b0;
            ptime_reg   <= '0;
            hold_reg    <= '0;
        end else if (fire) begin
            pending_reg <= pending_next && !t_v;
            pbtn_reg    <= pbtn_next;
            ptime_reg   <= ptime_next;
            hold_reg    <= hold_next;
        end
    end

endmodule

`default_nettype wire

@@ hdl/tgdp_fifo.sv @@
// ---------------------------------------------------------------------------
// tgdp_fifo
// Four-entry result queue taking up to two items a cycle, giving one.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tgdp_fifo (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic [1:0]      push_cnt,
    input  wire tgdp_pkg::res_t  push0,
    input  wire tgdp_pkg::res_t  push1,
    output logic                 room,
    output logic                 pop_valid,
    input  wire logic            pop_ready,
    output tgdp_pkg::res_t       pop_data
);

    tgdp_pkg::res_t                 mem [tgdp_pkg::QDEPTH];
    logic [tgdp_pkg::QPTR_W-1:0]    wr_reg, wr_next, wr_plus1;
    logic [tgdp_pkg::QPTR_W-1:0]    rd_reg, rd_next;
    logic [tgdp_pkg::QCNT_W-1:0]    cnt_reg, cnt_next;
    logic                           pop;

    assign pop       = pop_valid && pop_ready;
    assign pop_valid = (cnt_reg != '0);
    assign pop_data  = mem[rd_reg];
    // two free slots needed for the worst-case pass
    assign room      = (cnt_reg <= tgdp_pkg::QCNT_W'(tgdp_pkg::QDEPTH - 2));
    assign wr_plus1  = wr_reg + 1'b1;
    assign wr_next   = wr_reg + tgdp_pkg::QPTR_W'(push_cnt);
    assign rd_next   = rd_reg + tgdp_pkg::QPTR_W'(pop);
    assign cnt_next  = cnt_reg + tgdp_pkg::QCNT_W'(push_cnt) - tgdp_pkg::QCNT_W'(pop);

    always_ff @(posedge aclk) begin
        if (push_cnt != 2'd0) begin
            mem[wr_reg] <= push0;
        end
        if (push_cnt == 2'd2) begin
            mem[wr_plus1] <= push1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

`default_nettype wire

@@ hdl/tilt_gated_double_press_classifier_unit.sv @@
// ---------------------------------------------------------------------------
// tilt_gated_double_press_classifier_unit
// Classifies button releases of gated polling passes into single, double
// and both-button messages.
// ---------------------------------------------------------------------------
// Usage:
//   s_ channel: one polling pass per item (time, beacon, tilt, release flags).
//   m_ channel: zero, one or two messages per pass; m_tlast marks the final
//   message of a pass. A pass that yields nothing shows no item at all.
//   cfg port: write enable, register index, data; write only while idle.
// Path: an accepted pass waits in the input register until the result queue
//   has two free slots, is classified then, and its messages are written to
//   the queue, from which they are offered on the m_ channel.
// Throughput: one pass per cycle. The output side moves one message per
//   cycle, so a pass with two messages takes longer to leave than to enter; the
//   four-entry result queue absorbs that and the input stalls only when
//   fewer than two queue slots are free.
// Reset (aresetn low, synchronous): queue and input register emptied,
//   classifier state cleared, registers back to their defaults.
// Stall: with m_tready low the queue fills, the input register holds its
//   pass, and s_tready drops; nothing is lost or reordered.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tilt_gated_double_press_classifier_unit (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // slave side: time_ms, beacon_present, beacon_id, accel_z,
    //             release_left, release_right, release_both, zero pad
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [tgdp_pkg::S_TDATA_W-1:0]    s_tdata,
    // master side: button_code, is_double, target_valid, target_id, zero pad
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [tgdp_pkg::M_TDATA_W-1:0]         m_tdata,
    output logic                                   m_tlast,
    // configuration write port
    input  wire logic                              cfg_wr_en,
    input  wire logic [tgdp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [tgdp_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    tgdp_pkg::cfg_t      cfg_reg;
    tgdp_pkg::in_item_t  in_reg;
    logic                in_valid_reg;
    logic                fire;
    logic                room;
    tgdp_pkg::res_t      res0, res1, q_out;
    logic [1:0]          res_cnt, push_cnt;

    // Register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.enable         <= 1'b1;
            cfg_reg.window_ms      <= tgdp_pkg::RST_WINDOW;
            cfg_reg.holdoff_passes <= tgdp_pkg::RST_HOLDOFF;
            cfg_reg.tilt_low       <= tgdp_pkg::RST_TILT_LOW;
            cfg_reg.tilt_high      <= tgdp_pkg::RST_TILT_HIGH;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                tgdp_pkg::REG_ENABLE:    cfg_reg.enable <= cfg_wdata[0];
                tgdp_pkg::REG_WINDOW:    cfg_reg.window_ms <= cfg_wdata[tgdp_pkg::WIN_W-1:0];
                tgdp_pkg::REG_HOLDOFF:   cfg_reg.holdoff_passes <=
                                             cfg_wdata[tgdp_pkg::HOLD_W-1:0];
                tgdp_pkg::REG_TILT_LOW:  cfg_reg.tilt_low <= cfg_wdata[tgdp_pkg::ACCEL_W-1:0];
                tgdp_pkg::REG_TILT_HIGH: cfg_reg.tilt_high <= cfg_wdata[tgdp_pkg::ACCEL_W-1:0];
                default: ;  // drop writes beyond the register list
            endcase
        end
    end

    // Input register: process when the queue has two free slots
    assign fire     = in_valid_reg && room;
    assign s_tready = !in_valid_reg || fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_reg <= s_tdata[tgdp_pkg::IN_BITS-1:0];
        end
    end

    tgdp_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .item    (in_reg),
        .cfg     (cfg_reg),
        .res0    (res0),
        .res1    (res1),
        .res_cnt (res_cnt)
    );

    // push nothing unless the pass is actually consumed this cycle
    assign push_cnt = fire ? res_cnt : 2'd0;

    tgdp_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_cnt  (push_cnt),
        .push0     (res0),
        .push1     (res1),
        .room      (room),
        .pop_valid (m_tvalid),
        .pop_ready (m_tready),
        .pop_data  (q_out)
    );

    assign m_tdata = tgdp_pkg::M_TDATA_W'(q_out.data);
    assign m_tlast = q_out.last;

endmodule

`default_nettype wire

@@ hdl/tgdp_checker.sv @@
// ---------------------------------------------------------------------------
// tgdp_checker
// Port-level checks of the classifier, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "tilt_gated_double_press_classifier_unit_defines.svh"

module tgdp_checker (
    input wire logic                           aclk,
    input wire logic                           aresetn,
    input wire logic                           m_tvalid,
    input wire logic                           m_tready,
    input wire logic [tgdp_pkg::M_TDATA_W-1:0] m_tdata,
    input wire logic                           m_tlast
);

    `TGDP_ASSERT_RST(a_reset_empties, aclk, !aresetn, !m_tvalid)
    `TGDP_ASSERT_IMP(a_code_legal, aclk, aresetn, m_tvalid, m_tdata[1:0] != 2'd3)
    `TGDP_ASSERT_IMP(a_both_single, aclk, aresetn, m_tvalid && (m_tdata[1:0] == tgdp_pkg::BTN_BOTH), (!m_tdata[2]) && m_tlast)
    `TGDP_ASSERT_IMP(a_no_target_id, aclk, aresetn, m_tvalid && !m_tdata[3], m_tdata[tgdp_pkg::ID_W+3:4] == '0)
    `TGDP_ASSERT_NXT(a_stall_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast))

endmodule

bind tilt_gated_double_press_classifier_unit tgdp_checker u_tgdp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire

@@ dv/tilt_gated_double_press_classifier_unit_tb.sv @@
// ---------------------------------------------------------------------------
// tilt_gated_double_press_classifier_unit_tb
// Self-checking bench for the double-press classifier. It runs a directed
// table of polling passes first, then random phases under several register
// settings, with random input gaps and output stalls in all but one quiet
// phase. Messages are checked in order against a cycle-free model of the
// classifier or against the messages typed into hand-checked rows.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tilt_gated_double_press_classifier_unit_tb;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int SETTLE_CYCLES = 8;   // pipeline is two deep; leave margin

    // One row of the directed table. When hand_checked is set, the messages
    // typed into the row are used as the expected output. The model still
    // advances its state on every row.
    typedef struct {
        tgdp_pkg::in_item_t  pass;
        bit                  hand_checked;
        int                  msg_count;
        tgdp_pkg::out_data_t msg0;
        tgdp_pkg::out_data_t msg1;
    } pass_row_t;

    // Clock, reset and DUT ports
    logic                            aclk = 1'b0;
    logic                            aresetn = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [tgdp_pkg::S_TDATA_W-1:0]  s_tdata = '0;    // time_ms, beacon_present,
                                                      // beacon_id, accel_z,
                                                      // release_left, release_right,
                                                      // release_both, pad
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [tgdp_pkg::M_TDATA_W-1:0]  m_tdata;         // button_code, is_double,
                                                      // target_valid, target_id, pad
    logic                            m_tlast;
    logic                            cfg_wr_en = 1'b0;
    logic [tgdp_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [tgdp_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

    // Classifier model: register copy and state
    tgdp_pkg::cfg_t              cfg_q;
    logic                        press_pending;
    logic [1:0]                  pending_button;
    logic [tgdp_pkg::TIME_W-1:0] press_time;
    logic [tgdp_pkg::HOLD_W-1:0] holdoff_count;

    // Messages still owed by the DUT, oldest first
    tgdp_pkg::res_t msg_queue[$];

    pass_row_t   pass_table[$];
    int          mismatch_count = 0;
    int          cycle_count = 0;
    int          stall_left = 0;
    bit          calm = 1'b0;            // no gaps and no stalls while set
    logic [tgdp_pkg::TIME_W-1:0] now_ms = '0;

    tilt_gated_double_press_classifier_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Gap length: mostly none, sometimes a few cycles, rarely a long one
    function automatic int pick_gap();
        int sel;
        sel = $urandom_range(99);
        if (sel < 70) begin
            return 0;
        end else if (sel < 95) begin
            return $urandom_range(3, 1);
        end
        return $urandom_range(40, 10);
    endfunction

    function automatic tgdp_pkg::out_data_t msg(logic [1:0] code, logic dbl,
                                                logic tgt_valid,
                                                logic [tgdp_pkg::ID_W-1:0] id);
        tgdp_pkg::out_data_t m;
        m.button_code  = code;
        m.is_double    = dbl;
        m.target_valid = tgt_valid;
        m.target_id    = tgt_valid ? id : '0;
        return m;
    endfunction

    function automatic tgdp_pkg::cfg_t make_cfg(logic en,
                                                logic [tgdp_pkg::WIN_W-1:0] win,
                                                logic [tgdp_pkg::HOLD_W-1:0] hold,
                                                logic signed [tgdp_pkg::ACCEL_W-1:0] lo,
                                                logic signed [tgdp_pkg::ACCEL_W-1:0] hi);
        tgdp_pkg::cfg_t c;
        c.enable         = en;
        c.window_ms      = win;
        c.holdoff_passes = hold;
        c.tilt_low       = lo;
        c.tilt_high      = hi;
        return c;
    endfunction

    function automatic void add_row(logic [tgdp_pkg::TIME_W-1:0] t, logic bp,
                                    logic [tgdp_pkg::ID_W-1:0] id,
                                    logic signed [tgdp_pkg::ACCEL_W-1:0] az, logic rl,
                                    logic rr, logic rb, bit hand, int n,
                                    tgdp_pkg::out_data_t m0, tgdp_pkg::out_data_t m1);
        pass_row_t row;
        row.pass.time_ms        = t;
        row.pass.beacon_present = bp;
        row.pass.beacon_id      = id;
        row.pass.accel_z        = az;
        row.pass.release_left   = rl;
        row.pass.release_right  = rr;
        row.pass.release_both   = rb;
        row.hand_checked        = hand;
        row.msg_count           = n;
        row.msg0                = m0;
        row.msg1                = m1;
        pass_table.push_back(row);
    endfunction

    // Advance the classifier model by one pass. Queue its messages when
    // record is set; the last one of the pass carries the end-of-pass mark.
    function automatic void classify_pass(tgdp_pkg::in_item_t p, bit record);
        tgdp_pkg::res_t              msgs[$];
        tgdp_pkg::res_t              r;
        logic                        qualifies;
        logic                        in_window;
        logic [tgdp_pkg::TIME_W-1:0] gap;
        logic [1:0]                  btn;
        // Disabled: nothing comes out and the state holds, timeout included
        if (!cfg_q.enable) begin
            return;
        end
        qualifies = p.beacon_present
                    && ($signed(p.accel_z) > $signed(cfg_q.tilt_low))
                    && ($signed(p.accel_z) < $signed(cfg_q.tilt_high));
        if (qualifies) begin
            gap       = p.time_ms - press_time;
            in_window = press_pending && (gap <= tgdp_pkg::TIME_W'(cfg_q.window_ms));
            if (holdoff_count != '0) begin
                // Holdoff swallows the pass and its releases
                holdoff_count = holdoff_count - 1'b1;
            end else if (p.release_both) begin
                // Flush the pending press first, whatever its age
                if (press_pending) begin
                    r.last = 1'b0;
                    r.data = msg(pending_button, 1'b0, p.beacon_present, p.beacon_id);
                    msgs.push_back(r);
                end
                r.last = 1'b0;
                r.data = msg(tgdp_pkg::BTN_BOTH, 1'b0, p.beacon_present, p.beacon_id);
                msgs.push_back(r);
                press_pending = 1'b0;
                holdoff_count = cfg_q.holdoff_passes;
            end else if (p.release_left || p.release_right) begin
                btn = p.release_left ? tgdp_pkg::BTN_LEFT : tgdp_pkg::BTN_RIGHT;
                if (in_window && pending_button == btn) begin
                    r.last = 1'b0;
                    r.data = msg(btn, 1'b1, p.beacon_present, p.beacon_id);
                    msgs.push_back(r);
                    press_pending = 1'b0;
                end else begin
                    // Mismatched or stale press goes out as a single
                    if (press_pending) begin
                        r.last = 1'b0;
                        r.data = msg(pending_button, 1'b0, p.beacon_present,
                                     p.beacon_id);
                        msgs.push_back(r);
                    end
                    press_pending  = 1'b1;
                    pending_button = btn;
                    press_time     = p.time_ms;
                end
            end
        end
        // Timeout runs on every enabled pass, with or without a beacon
        gap = p.time_ms - press_time;
        if (press_pending && gap > tgdp_pkg::TIME_W'(cfg_q.window_ms)) begin
            r.last = 1'b0;
            r.data = msg(pending_button, 1'b0, p.beacon_present, p.beacon_id);
            msgs.push_back(r);
            press_pending = 1'b0;
        end
        if (msgs.size() > 0) begin
            msgs[msgs.size() - 1].last = 1'b1;
        end
        if (record) begin
            foreach (msgs[i]) begin
                msg_queue.push_back(msgs[i]);
            end
        end
    endfunction

    // Random pass shaped around the current settings: mostly qualifying
    // passes whose spacing lands near the double-press window.
    function automatic tgdp_pkg::in_item_t random_pass();
        tgdp_pkg::in_item_t p;
        int                 sel;
        int                 lo;
        int                 hi;
        sel = $urandom_range(99);
        if (sel < 40) begin
            now_ms = now_ms + tgdp_pkg::TIME_W'($urandom_range(cfg_q.window_ms));
        end else if (sel < 70) begin
            now_ms = now_ms + tgdp_pkg::TIME_W'(cfg_q.window_ms) - tgdp_pkg::TIME_W'(2)
                     + tgdp_pkg::TIME_W'($urandom_range(4));
        end else if (sel < 90) begin
            now_ms = now_ms + tgdp_pkg::TIME_W'($urandom_range(100000));
        end else begin
            now_ms = tgdp_pkg::TIME_W'($urandom());
        end
        p.time_ms        = now_ms;
        p.beacon_present = ($urandom_range(9) != 0);
        p.beacon_id      = tgdp_pkg::ID_W'($urandom());

        lo  = int'($signed(cfg_q.tilt_low)) + 1;
        hi  = int'($signed(cfg_q.tilt_high)) - 1;
        sel = $urandom_range(99);
        if (sel < 80 && lo <= hi) begin
            p.accel_z = tgdp_pkg::ACCEL_W'(lo + int'($urandom_range(hi - lo)));
        end else if (sel < 90) begin
            case ($urandom_range(3))
                0: p.accel_z = cfg_q.tilt_low;
                1: p.accel_z = cfg_q.tilt_high;
                2: p.accel_z = cfg_q.tilt_low + 16'sd1;
                default: p.accel_z = cfg_q.tilt_high - 16'sd1;
            endcase
        end else begin
            p.accel_z = tgdp_pkg::ACCEL_W'($urandom());
        end

        {p.release_both, p.release_right, p.release_left} = 3'b000;
        sel = $urandom_range(99);
        if (sel < 30) begin
            // no release this pass
        end else if (sel < 55) begin
            p.release_left = 1'b1;
        end else if (sel < 80) begin
            p.release_right = 1'b1;
        end else if (sel < 90) begin
            p.release_both = 1'b1;
        end else begin
            {p.release_both, p.release_right, p.release_left} = 3'($urandom());
        end
        return p;
    endfunction

    // Present one pass and hold it until the DUT takes it
    task automatic send_pass(tgdp_pkg::in_item_t p);
        s_tdata  <= tgdp_pkg::S_TDATA_W'(p);
        s_tvalid <= 1'b1;
        do begin
            @(posedge aclk);
        end while (!(s_tvalid && s_tready));
    endtask

    // Optional idle cycles after an accepted pass
    task automatic source_gap();
        int g;
        g = calm ? 0 : pick_gap();
        if (g > 0) begin
            s_tvalid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
    endtask

    // Drop valid, wait for every owed message, then let the pipe settle
    task automatic drain();
        s_tvalid <= 1'b0;
        while (msg_queue.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // One register per cycle; write enable stays high across the burst
    task automatic put_reg(logic [tgdp_pkg::CFG_IDX_W-1:0] idx,
                           logic [tgdp_pkg::CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
    endtask

    task automatic program_regs(tgdp_pkg::cfg_t c);
        put_reg(tgdp_pkg::REG_ENABLE, tgdp_pkg::CFG_DATA_W'(c.enable));
        put_reg(tgdp_pkg::REG_WINDOW, tgdp_pkg::CFG_DATA_W'(c.window_ms));
        put_reg(tgdp_pkg::REG_HOLDOFF, tgdp_pkg::CFG_DATA_W'(c.holdoff_passes));
        put_reg(tgdp_pkg::REG_TILT_LOW, tgdp_pkg::CFG_DATA_W'(c.tilt_low));
        put_reg(tgdp_pkg::REG_TILT_HIGH, tgdp_pkg::CFG_DATA_W'(c.tilt_high));
        cfg_wr_en <= 1'b0;
        cfg_q = c;
    endtask

    task automatic run_phase(tgdp_pkg::cfg_t c, int n_passes, bit quiet);
        tgdp_pkg::in_item_t p;
        program_regs(c);
        calm = quiet;
        repeat (n_passes) begin
            p = random_pass();
            send_pass(p);
            classify_pass(p, 1'b1);
            source_gap();
        end
        drain();
    endtask

    // Output side: random stalls, long ones now and then
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            if (!calm && $urandom_range(99) < 20) begin
                stall_left <= pick_gap();
            end
        end
    end

    // Compare each accepted message with the oldest one owed
    always @(posedge aclk) begin
        tgdp_pkg::out_data_t got;
        tgdp_pkg::res_t      want;
        if (aresetn && m_tvalid && m_tready) begin
            got = tgdp_pkg::out_data_t'(m_tdata[tgdp_pkg::OUT_BITS-1:0]);
            if (msg_queue.size() == 0) begin
                $error("unexpected message: tdata %h tlast %b", m_tdata, m_tlast);
                mismatch_count = mismatch_count + 1;
            end else begin
                want = msg_queue.pop_front();
                if (got.button_code !== want.data.button_code) begin
                    $error("button_code: expected %0d, got %0d",
                           want.data.button_code, got.button_code);
                    mismatch_count = mismatch_count + 1;
                end
                if (got.is_double !== want.data.is_double) begin
                    $error("is_double: expected %0b, got %0b",
                           want.data.is_double, got.is_double);
                    mismatch_count = mismatch_count + 1;
                end
                if (got.target_valid !== want.data.target_valid) begin
                    $error("target_valid: expected %0b, got %0b",
                           want.data.target_valid, got.target_valid);
                    mismatch_count = mismatch_count + 1;
                end
                if (got.target_id !== want.data.target_id) begin
                    $error("target_id: expected %0d, got %0d",
                           want.data.target_id, got.target_id);
                    mismatch_count = mismatch_count + 1;
                end
                if (m_tlast !== want.last) begin
                    $error("last: expected %0b, got %0b", want.last, m_tlast);
                    mismatch_count = mismatch_count + 1;
                end
            end
        end
    end

    // Watchdog: abandon a hung run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        tgdp_pkg::out_data_t none;
        pass_row_t           row;
        none = '0;

        // Model starts from the reset values of state and registers
        cfg_q          = make_cfg(1'b1, tgdp_pkg::RST_WINDOW, tgdp_pkg::RST_HOLDOFF,
                                  tgdp_pkg::RST_TILT_LOW, tgdp_pkg::RST_TILT_HIGH);
        press_pending  = 1'b0;
        pending_button = tgdp_pkg::BTN_LEFT;
        press_time     = '0;
        holdoff_count  = '0;

        // Directed table, run with the reset settings: window 300 ms,
        // holdoff 10, tilt strictly between 1280 and 3840.
        //      time           bp    id      accel      L     R     B
        // first press goes pending, second within the window is a double
        add_row(32'd1000,      1'b1, 8'hFF, 16'sd2000, 1'b1, 1'b0, 1'b0, 1, 0, none, none);
        add_row(32'd1100,      1'b1, 8'hFF, 16'sd2000, 1'b1, 1'b0, 1'b0, 1, 1,
                msg(tgdp_pkg::BTN_LEFT, 1'b1, 1'b1, 8'hFF), none);
        // press that ages out on a quiet pass becomes a single
        add_row(32'd1200,      1'b1, 8'h01, 16'sd2000, 1'b0, 1'b1, 1'b0, 1, 0, none, none);
        add_row(32'd1600,      1'b1, 8'h00, 16'sd2000, 1'b0, 1'b0, 1'b0, 1, 1,
                msg(tgdp_pkg::BTN_RIGHT, 1'b0, 1'b1, 8'h00), none);
        // tilt just inside both bounds; other button flushes the pending one
        add_row(32'd1700,      1'b1, 8'h3C, 16'sd1281, 1'b0, 1'b1, 1'b0, 1, 0, none, none);
        add_row(32'd1750,      1'b1, 8'hC3, 16'sd3839, 1'b1, 1'b0, 1'b0, 1, 1,
                msg(tgdp_pkg::BTN_RIGHT, 1'b0, 1'b1, 8'hC3), none);
        // no beacon: release ignored, then timeout without a target
        add_row(32'd1800,      1'b0, 8'hAA, 16'sd2000, 1'b1, 1'b0, 1'b0, 1, 0, none, none);
        add_row(32'd2051,      1'b0, 8'h55, 16'sd2000, 1'b0, 1'b0, 1'b0, 1, 1,
                msg(tgdp_pkg::BTN_LEFT, 1'b0, 1'b0, 8'h00), none);
        // tilt on the bounds and at the extremes never qualifies
        add_row(32'd3000,      1'b1, 8'h11, 16'sd1280, 1'b1, 1'b0, 1'b0, 1, 0, none, none);
        add_row(32'd3001,      1'b1, 8'h22, 16'sd3840, 1'b0, 1'b1, 1'b0, 1, 0, none, none);
        add_row(32'd3002,      1'b1, 8'h33, -16'sd32768, 1'b1, 1'b0, 1'b0, 1, 0, none, none);
        add_row(32'd3003,      1'b1, 8'h44, 16'sd32767, 1'b0, 1'b0, 1'b1, 1, 0, none, none);
        // double across the wrap of the millisecond counter
        add_row(32'hFFFF_FFF0, 1'b1, 8'h80, 16'sd2000, 1'b1, 1'b0, 1'b0, 1, 0, none, none);
        add_row(32'h0000_0010, 1'b1, 8'h7F, 16'sd2000, 1'b1, 1'b0, 1'b0, 1, 1,
                msg(tgdp_pkg::BTN_LEFT, 1'b1, 1'b1, 8'h7F), none);
        // left beats right; a gap of exactly the window still counts
        add_row(32'd4000,      1'b1, 8'h5A, 16'sd2000, 1'b1, 1'b1, 1'b0, 0, 0, none, none);
        add_row(32'd4010,      1'b1, 8'hA5, 16'sd2000, 1'b0, 1'b1, 1'b0, 0, 0, none, none);
        add_row(32'd4310,      1'b1, 8'h0F, 16'sd2000, 1'b0, 1'b1, 1'b0, 0, 0, none, none);
        // both-release wins over the others and flushes the pending press
        add_row(32'd4400,      1'b1, 8'hF0, 16'sd2000, 1'b0, 1'b1, 1'b0, 1, 0, none, none);
        add_row(32'd4401,      1'b1, 8'h96, 16'sd2000, 1'b1, 1'b1, 1'b1, 1, 2,
                msg(tgdp_pkg::BTN_RIGHT, 1'b0, 1'b1, 8'h96),
                msg(tgdp_pkg::BTN_BOTH, 1'b0, 1'b1, 8'h96));
        // holdoff swallows qualifying passes; others do not count it down
        add_row(32'd4402,      1'b1, 8'h69, 16'sd2000, 1'b1, 1'b0, 1'b0, 0, 0, none, none);
        add_row(32'd4403,      1'b0, 8'h69, 16'sd2000, 1'b1, 1'b0, 1'b0, 0, 0, none, none);
        add_row(32'd4404,      1'b1, 8'h69, 16'sd2000, 1'b0, 1'b1, 1'b0, 0, 0, none, none);
        add_row(32'hFFFF_FFFF, 1'b1, 8'h00, 16'sd0,    1'b0, 1'b0, 1'b0, 0, 0, none, none);

        // Hold reset, then release it once
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Walk the directed table
        foreach (pass_table[i]) begin
            row = pass_table[i];
            send_pass(row.pass);
            classify_pass(row.pass, !row.hand_checked);
            if (row.hand_checked) begin
                if (row.msg_count > 0) begin
                    msg_queue.push_back('{last: (row.msg_count == 1), data: row.msg0});
                end
                if (row.msg_count > 1) begin
                    msg_queue.push_back('{last: 1'b1, data: row.msg1});
                end
            end
            source_gap();
        end
        drain();
        now_ms = 32'd5000;

        // Random phases: defaults, extremes, narrow and empty tilt windows,
        // disabled, and random settings
        run_phase(make_cfg(1'b1, tgdp_pkg::RST_WINDOW, tgdp_pkg::RST_HOLDOFF,
                           tgdp_pkg::RST_TILT_LOW, tgdp_pkg::RST_TILT_HIGH), 280, 1'b0);
        run_phase(make_cfg(1'b1, 16'd0, 8'd0, -16'sd32768, 16'sd32767), 280, 1'b0);
        run_phase(make_cfg(1'b1, 16'd65535, 8'd255, -16'sd100, 16'sd100), 280, 1'b1);
        run_phase(make_cfg(1'b1, 16'd50, 8'd1, 16'sd0, 16'sd2), 200, 1'b0);
        run_phase(make_cfg(1'b0, 16'($urandom()), 8'($urandom()), 16'($urandom()),
                           16'($urandom())), 60, 1'b0);
        run_phase(make_cfg(1'b1, 16'd300, 8'd3, 16'sd3840, 16'sd1280), 80, 1'b0);
        run_phase(make_cfg(1'b1, 16'd120, 8'd2, 16'sd32767, -16'sd32768), 60, 1'b0);
        run_phase(make_cfg(1'b1, 16'($urandom_range(1000)), 8'($urandom_range(15)),
                           -16'sd2000, 16'sd6000), 280, 1'b0);
        run_phase(make_cfg(1'b1, 16'($urandom()), 8'($urandom()), 16'($urandom()),
                           16'($urandom())), 200, 1'b0);

        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

@@ files.f @@
+incdir+hdl
hdl/tgdp_pkg.sv
hdl/tgdp_core.sv
hdl/tgdp_fifo.sv
hdl/tilt_gated_double_press_classifier_unit.sv
hdl/tgdp_checker.sv
dv/tilt_gated_double_press_classifier_unit_tb.sv
